>>> rtl/core/ldmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldmf_pkg
// Shared types, codes and reset constants of the LED dimmer/mixer/fader.
// ----------------------------------------------------------------------------
package ldmf_pkg;

    localparam int LDMF_MAX_CH    = 5;
    localparam int LDMF_CHANNELS  = 5;
    localparam int LDMF_DUTY_BITS = 11;
    localparam int LDMF_ADDR_W    = 5;

    localparam logic [10:0] FULL_SCALE = 11'd1024;

    // command codes
    localparam logic [3:0] CMD_TICK        = 4'd0;
    localparam logic [3:0] CMD_SET_POWER   = 4'd1;
    localparam logic [3:0] CMD_TOGGLE      = 4'd2;
    localparam logic [3:0] CMD_SET_BRIGHT  = 4'd3;
    localparam logic [3:0] CMD_BRIGHT_UP   = 4'd4;
    localparam logic [3:0] CMD_BRIGHT_DOWN = 4'd5;
    localparam logic [3:0] CMD_SET_MIX     = 4'd6;
    localparam logic [3:0] CMD_MIX_UP      = 4'd7;
    localparam logic [3:0] CMD_MIX_DOWN    = 4'd8;
    localparam logic [3:0] CMD_SET_LEVEL   = 4'd9;
    localparam logic [3:0] CMD_LEVEL_UP    = 4'd10;
    localparam logic [3:0] CMD_LEVEL_DOWN  = 4'd11;

    // channel mapping mode codes
    localparam logic [2:0] MODE_SINGLE = 3'd0;
    localparam logic [2:0] MODE_CCT    = 3'd1;
    localparam logic [2:0] MODE_RGB    = 3'd2;
    localparam logic [2:0] MODE_RGBW   = 3'd3;
    localparam logic [2:0] MODE_RGBWW  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_MAX       = 3'd1;
    localparam logic [2:0] REG_FADE      = 3'd2;
    localparam logic [2:0] REG_BSTEP     = 3'd3;
    localparam logic [2:0] REG_LSTEP     = 3'd4;
    localparam logic [2:0] REG_MIN_BRIGHT = 3'd5;

    // reset values
    localparam logic [2:0]  RST_MODE       = MODE_CCT;
    localparam logic [10:0] RST_MAX        = 11'd1023;
    localparam logic [10:0] RST_FADE       = 11'd8;
    localparam logic [10:0] RST_BSTEP      = 11'd32;
    localparam logic [10:0] RST_LSTEP      = 11'd32;
    localparam logic [10:0] RST_MIN_BRIGHT = 11'd1;
    localparam logic [10:0] RST_BRIGHTNESS = 11'd256;

    typedef struct packed {
        logic [3:0]  command;
        logic [2:0]  channel;
        logic [15:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic [10:0] duty_0;
        logic [10:0] duty_1;
        logic [10:0] duty_2;
        logic [10:0] duty_3;
        logic [10:0] duty_4;
        logic        power_on;
        logic [10:0] brightness_now;
        logic [10:0] mix_now;
    } t_duty_out;

    // per-item control handed to each channel
    typedef struct packed {
        logic        adv;
        logic        tick;
        logic        recalc;
        logic        power;
        logic [10:0] brightness;
        logic [10:0] fade_step;
    } t_chan_ctl;

endpackage

>>> rtl/core/ldmf_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldmf_chan
// One dimmer channel: target duty from brightness and a scale factor, and
// the current duty that fades toward the target on each tick.
// ----------------------------------------------------------------------------
module ldmf_chan #(
    parameter int DUTY_BITS  = 11,
    parameter int RST_TARGET = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ldmf_pkg::t_chan_ctl    i_ctl,
    input  logic                   i_sel,
    input  logic [10:0]            i_factor,
    output logic [DUTY_BITS-1:0]   o_duty_next
);
    import ldmf_pkg::*;

    logic [DUTY_BITS-1:0] r_target, n_target;
    logic [DUTY_BITS-1:0] r_current, w_faded;
    logic [21:0]          w_prod;
    logic [10:0]          w_tgt;
    logic [16:0]          w_c, w_t, w_fs, w_diff, w_inc, w_sum;

    assign w_prod = 22'(i_ctl.brightness) * 22'(i_factor);
    assign w_tgt  = i_ctl.power ? w_prod[20:10] : 11'd0;

    assign n_target = (i_ctl.recalc && i_sel) ? DUTY_BITS'(w_tgt) : r_target;

    // move current toward target by at most fade_step
    always_comb begin
        w_c  = 17'(r_current);
        w_t  = 17'(r_target);
        w_fs = 17'(i_ctl.fade_step);
        if (w_t > w_c) begin
            w_diff = w_t - w_c;
            w_inc  = (w_diff > w_fs) ? w_fs : w_diff;
            w_sum  = w_c + w_inc;
        end else begin
            w_diff = w_c - w_t;
            w_inc  = (w_diff > w_fs) ? w_fs : w_diff;
            w_sum  = w_c - w_inc;
        end
        w_faded = DUTY_BITS'(w_sum);
    end

    assign o_duty_next = i_ctl.tick ? w_faded : r_current;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= DUTY_BITS'(RST_TARGET);
            r_current <= '0;
        end else if (i_ctl.adv) begin
            r_target  <= n_target;
            r_current <= o_duty_next;
        end
    end

endmodule

>>> rtl/core/led_dimmer_mixer_fader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_dimmer_mixer_fader
// Five-channel LED dimmer: power, brightness, warm/cold mix and channel
// level commands, per-mode channel targets and a tick-driven fade ramp.
// ----------------------------------------------------------------------------
//  channel   signals                               moves
//  command   i_cmd_valid / o_cmd_ready / i_cmd     command, channel, value
//  result    o_res_valid / i_res_ready / o_res     duties, power, brightness, mix
//  config    psel penable pwrite paddr pwdata      six registers at 4*index
//
//  One command per cycle while results are taken; each result passes the
//  channel stage and then the result register. Settings update at the command
//  transfer; targets and the fade step update in the channel stage.
//  Synchronous active-low reset restores the reset settings and targets.
//  A held result stalls the channel stage and then the command side.
// ----------------------------------------------------------------------------
module led_dimmer_mixer_fader #(
    parameter int CHANNELS  = ldmf_pkg::LDMF_CHANNELS,
    parameter int DUTY_BITS = ldmf_pkg::LDMF_DUTY_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  ldmf_pkg::t_cmd_in                 i_cmd,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output ldmf_pkg::t_duty_out               o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ldmf_pkg::LDMF_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import ldmf_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] CH_LIM = 4'(CHANNELS);

    // configuration
    logic [2:0]  r_mode;
    logic [10:0] r_max, r_fade, r_bstep, r_lstep, r_minb;
    logic [2:0]  w_reg_idx;
    logic        w_cfg_wr;

    // settings
    logic        r_power, n_power;
    logic [10:0] r_bright, n_bright;
    logic [10:0] r_mix, n_mix;
    logic [10:0] r_level [CHANNELS];
    logic        n_level_wr;

    // command decode
    logic        w_accept;
    logic        w_ch_ok;
    logic [CH_IDX_W-1:0] w_ch_idx;
    logic [10:0] w_bound, w_old, w_step, w_floor, w_lvl_old;
    logic [10:0] w_set_res, w_up_res, w_down_res, w_res;
    logic [11:0] w_sum;
    logic [10:0] w_dn;
    logic        w_up, w_down;
    logic        n_chg, n_tick;

    // pipeline control
    logic        r_stg_valid, r_stg_tick, r_stg_chg;
    logic        r_out_valid;
    logic        w_out_free, w_stg_adv;
    t_duty_out   r_out;
    t_chan_ctl   w_ctl;
    logic [10:0] w_duty [LDMF_MAX_CH];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[LDMF_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_max   <= RST_MAX;
            r_fade  <= RST_FADE;
            r_bstep <= RST_BSTEP;
            r_lstep <= RST_LSTEP;
            r_minb  <= RST_MIN_BRIGHT;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_MODE:       r_mode  <= pwdata[2:0];
                REG_MAX:        r_max   <= pwdata[10:0];
                REG_FADE:       r_fade  <= pwdata[10:0];
                REG_BSTEP:      r_bstep <= pwdata[10:0];
                REG_LSTEP:      r_lstep <= pwdata[10:0];
                REG_MIN_BRIGHT: r_minb  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MODE:       prdata = 32'(r_mode);
            REG_MAX:        prdata = 32'(r_max);
            REG_FADE:       prdata = 32'(r_fade);
            REG_BSTEP:      prdata = 32'(r_bstep);
            REG_LSTEP:      prdata = 32'(r_lstep);
            REG_MIN_BRIGHT: prdata = 32'(r_minb);
            default:        prdata = '0;
        endcase
    end

    // ---------------- command decode and settings ----------------
    assign w_out_free  = !r_out_valid || i_res_ready;
    assign w_stg_adv   = r_stg_valid && w_out_free;
    assign o_cmd_ready = !r_stg_valid || w_out_free;
    assign w_accept    = i_cmd_valid && o_cmd_ready;

    assign w_ch_ok   = {1'b0, i_cmd.channel} < CH_LIM;
    assign w_ch_idx  = i_cmd.channel[CH_IDX_W-1:0];
    assign w_lvl_old = w_ch_ok ? r_level[w_ch_idx] : 11'd0;
    assign w_bound   = (r_max > FULL_SCALE) ? FULL_SCALE : r_max;

    // select the operand, step and floor of the set/step path
    always_comb begin
        w_old   = r_bright;
        w_step  = r_lstep;
        w_floor = 11'd0;
        w_up    = 1'b0;
        w_down  = 1'b0;
        case (i_cmd.command) inside
            CMD_SET_BRIGHT, CMD_BRIGHT_UP, CMD_BRIGHT_DOWN: begin
                w_old  = r_bright;
                w_step = r_bstep;
            end
            CMD_SET_MIX, CMD_MIX_UP, CMD_MIX_DOWN: w_old = r_mix;
            CMD_SET_LEVEL, CMD_LEVEL_UP, CMD_LEVEL_DOWN: w_old = w_lvl_old;
            default: ;
        endcase
        case (i_cmd.command) inside
            CMD_BRIGHT_UP, CMD_MIX_UP, CMD_LEVEL_UP: w_up = 1'b1;
            CMD_BRIGHT_DOWN, CMD_MIX_DOWN, CMD_LEVEL_DOWN: w_down = 1'b1;
            default: ;
        endcase
        if (i_cmd.command == CMD_BRIGHT_DOWN) begin
            w_floor = r_minb;
        end
    end

    always_comb begin
        w_set_res = (i_cmd.value > 16'(w_bound)) ? w_bound : i_cmd.value[10:0];
        w_sum     = 12'(w_old) + 12'(w_step);
        w_up_res  = (w_sum > 12'(w_bound)) ? w_bound : w_sum[10:0];
        w_dn      = (w_old > w_step) ? (w_old - w_step) : 11'd0;
        if (w_dn < w_floor) begin
            w_dn = w_floor;
        end
        w_down_res = (w_dn > w_bound) ? w_bound : w_dn;
        if (w_up) begin
            w_res = w_up_res;
        end else if (w_down) begin
            w_res = w_down_res;
        end else begin
            w_res = w_set_res;
        end
    end

    always_comb begin
        n_power    = r_power;
        n_bright   = r_bright;
        n_mix      = r_mix;
        n_level_wr = 1'b0;
        n_chg      = 1'b1;
        n_tick     = 1'b0;
        case (i_cmd.command) inside
            CMD_TICK: begin
                n_tick = 1'b1;
                n_chg  = 1'b0;
            end
            CMD_SET_POWER:  n_power = i_cmd.value[0];
            CMD_TOGGLE:     n_power = ~r_power;
            CMD_SET_BRIGHT: n_bright = w_res;
            CMD_BRIGHT_UP, CMD_BRIGHT_DOWN: begin
                // ignore brightness steps while off
                if (r_power) begin
                    n_bright = w_res;
                end else begin
                    n_chg = 1'b0;
                end
            end
            CMD_SET_MIX, CMD_MIX_UP, CMD_MIX_DOWN: n_mix = w_res;
            CMD_SET_LEVEL, CMD_LEVEL_UP, CMD_LEVEL_DOWN: n_level_wr = w_ch_ok;
            default: n_chg = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power  <= 1'b1;
            r_bright <= RST_BRIGHTNESS;
            r_mix    <= '0;
        end else if (w_accept) begin
            r_power  <= n_power;
            r_bright <= n_bright;
            r_mix    <= n_mix;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_level
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_level[i] <= '0;
            end else if (w_accept && n_level_wr && (w_ch_idx == CH_IDX_W'(i))) begin
                r_level[i] <= w_res;
            end
        end
    end

    // ---------------- channel stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_stg_tick  <= 1'b0;
            r_stg_chg   <= 1'b0;
        end else if (o_cmd_ready) begin
            r_stg_valid <= w_accept;
            r_stg_tick  <= w_accept && n_tick;
            r_stg_chg   <= w_accept && n_chg;
        end
    end

    assign w_ctl.adv        = w_stg_adv;
    assign w_ctl.tick       = r_stg_tick;
    assign w_ctl.recalc     = r_stg_chg;
    assign w_ctl.power      = r_power;
    assign w_ctl.brightness = r_bright;
    assign w_ctl.fade_step  = r_fade;

    for (genvar i = 0; i < LDMF_MAX_CH; i++) begin : g_chan
        if (i < CHANNELS) begin : g_used
            logic                 w_sel;
            logic [10:0]          w_factor;
            logic [DUTY_BITS-1:0] w_next;
            logic [15:0]          w_ext;

            always_comb begin
                w_sel    = 1'b0;
                w_factor = 11'd0;
                unique case (r_mode)
                    MODE_SINGLE: begin
                        w_sel    = (i == 0);
                        w_factor = FULL_SCALE;
                    end
                    MODE_CCT: begin
                        w_sel    = (i < 2);
                        w_factor = (i == 0) ? r_mix : (FULL_SCALE - r_mix);
                    end
                    MODE_RGB: begin
                        w_sel    = (i < 3);
                        w_factor = r_level[i];
                    end
                    MODE_RGBW: begin
                        w_sel    = (i < 4);
                        w_factor = r_level[i];
                    end
                    MODE_RGBWW: begin
                        w_sel    = (i < 5);
                        w_factor = r_level[i];
                    end
                    default: ;
                endcase
            end

            ldmf_chan #(
                .DUTY_BITS  (DUTY_BITS),
                .RST_TARGET ((i == 1) ? int'(RST_BRIGHTNESS) : 0)
            ) u_chan (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_sel       (w_sel),
                .i_factor    (w_factor),
                .o_duty_next (w_next)
            );

            assign w_ext     = 16'(w_next);
            assign w_duty[i] = w_ext[10:0];
        end else begin : g_unused
            assign w_duty[i] = '0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stg_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stg_adv) begin
            r_out.duty_0         <= w_duty[0];
            r_out.duty_1         <= w_duty[1];
            r_out.duty_2         <= w_duty[2];
            r_out.duty_3         <= w_duty[3];
            r_out.duty_4         <= w_duty[4];
            r_out.power_on       <= r_power;
            r_out.brightness_now <= r_bright;
            r_out.mix_now        <= r_mix;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
